>>> hdl/mvm_pkg.sv
// ============================================================================
// Matrix-vector multiply package
// Field widths, register indexes, request codes and the control word that
// travels from the front end to the datapath.
// ============================================================================
package mvm_pkg;

    // Payload widths fixed by the item format
    localparam int VAL_W     = 16;   // Q4.12 element
    localparam int PROD_W    = 32;   // Q8.24 product
    localparam int SUM_W     = 38;   // Q14.24 row sum
    localparam int IDX_W     = 6;    // elem_index and row_index
    localparam int CFG_W     = 7;    // configuration register width
    localparam int CFG_IDX_W = 2;    // configuration register index

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_COLS   = 2'd0,
        CFG_NUM_ROWS   = 2'd1,
        CFG_VECTOR_LEN = 2'd2
    } cfg_idx_t;

    // Request codes
    localparam logic REQ_VECTOR = 1'b0;
    localparam logic REQ_MATRIX = 1'b1;

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    // Per-item control decided by the front end
    typedef struct packed {
        logic is_mat;     // matrix element, else vector load
        logic row_end;    // last element of its row
        logic last;       // row is the final row of the matrix
        logic mismatch;   // column count differs from vector length
    } mvm_ctrl_t;

endpackage

>>> hdl/mvm_req_if.sv
// ============================================================================
// Request channel
// Valid/ready channel carrying vector loads and streamed matrix elements.
// ============================================================================
interface mvm_req_if;
    logic                               valid;
    logic                               ready;
    logic                               req_type;
    logic signed [mvm_pkg::VAL_W-1:0]   elem_value;
    logic        [mvm_pkg::IDX_W-1:0]   elem_index;

    modport source (output valid, req_type, elem_value, elem_index, input ready);
    modport sink   (input valid, req_type, elem_value, elem_index, output ready);
endinterface

>>> hdl/mvm_res_if.sv
// ============================================================================
// Result channel
// Valid/ready channel carrying one row result per completed matrix row.
// ============================================================================
interface mvm_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [mvm_pkg::SUM_W-1:0]   row_sum;
    logic        [mvm_pkg::IDX_W-1:0]   row_index;
    logic                               last_row;
    logic                               status;

    modport source (output valid, row_sum, row_index, last_row, status, input ready);
    modport sink   (input valid, row_sum, row_index, last_row, status, output ready);
endinterface

>>> hdl/mvm_front.sv
// ============================================================================
// Matrix-vector multiply front end
// Holds the configuration registers and the column and row counters, takes
// request items and tags each one with its store address and row control.
// ============================================================================
module mvm_front #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    localparam int CW  = $clog2(MAX_COLS),
    localparam int RW  = $clog2(MAX_ROWS),
    localparam int CEW = $clog2(MAX_COLS + 1),
    localparam int REW = $clog2(MAX_ROWS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mvm_req_if.sink                             req,
    input  logic                                cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                q_full,
    output logic                                q_push,
    output mvm_pkg::mvm_ctrl_t                  q_ctrl,
    output logic signed [mvm_pkg::VAL_W-1:0]    q_value,
    output logic [CW-1:0]                       q_addr,
    output logic [RW-1:0]                       q_row
);

    localparam int CMW = (CEW > mvm_pkg::CFG_W) ? CEW : mvm_pkg::CFG_W;
    localparam int RMW = (REW > mvm_pkg::CFG_W) ? REW : mvm_pkg::CFG_W;
    localparam int LW  = (mvm_pkg::IDX_W > CEW) ? mvm_pkg::IDX_W : CEW;

    logic [mvm_pkg::CFG_W-1:0] cols_reg;
    logic [mvm_pkg::CFG_W-1:0] rows_reg;
    logic [mvm_pkg::CFG_W-1:0] vlen_reg;
    logic [CW-1:0]             col_reg;
    logic [CW-1:0]             col_next;
    logic [RW-1:0]             row_reg;
    logic [RW-1:0]             row_next;

    logic [CMW-1:0] eff_cols;
    logic [CMW-1:0] eff_vlen;
    logic [RMW-1:0] eff_rows;
    logic [CMW-1:0] col_inc;
    logic [RMW-1:0] row_inc;
    logic           accept;
    logic           is_mat;
    logic           load_ok;
    logic           row_end;
    logic           last;

    // Clamp a register to 1..MAX_COLS
    function automatic logic [CMW-1:0] clamp_col(input logic [mvm_pkg::CFG_W-1:0] v);
        logic [CMW-1:0] x;
        x = CMW'(v);
        if (x == '0)
            return CMW'(1);
        else if (x > CMW'(MAX_COLS))
            return CMW'(MAX_COLS);
        else
            return x;
    endfunction

    // Clamp a register to 1..MAX_ROWS
    function automatic logic [RMW-1:0] clamp_row(input logic [mvm_pkg::CFG_W-1:0] v);
        logic [RMW-1:0] x;
        x = RMW'(v);
        if (x == '0)
            return RMW'(1);
        else if (x > RMW'(MAX_ROWS))
            return RMW'(MAX_ROWS);
        else
            return x;
    endfunction

    // Classify the item and work out where its row stands
    always_comb
    begin
        eff_cols = clamp_col(cols_reg);
        eff_vlen = clamp_col(vlen_reg);
        eff_rows = clamp_row(rows_reg);
        col_inc  = CMW'(col_reg) + CMW'(1);
        row_inc  = RMW'(row_reg) + RMW'(1);
        row_end  = !(col_inc < eff_cols);
        last     = !(row_inc < eff_rows);
        is_mat   = (req.req_type == mvm_pkg::REQ_MATRIX);
        load_ok  = (LW'(req.elem_index) < LW'(MAX_COLS));
        accept   = req.valid && req.ready;

        col_next = col_reg;
        row_next = row_reg;
        if (accept && is_mat)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last ? '0 : RW'(row_inc);
            end
            else
            begin
                col_next = CW'(col_inc);
            end
        end
    end

    assign req.ready         = !q_full;
    assign q_push            = accept && (is_mat || load_ok);
    assign q_ctrl.is_mat     = is_mat;
    assign q_ctrl.row_end    = row_end;
    assign q_ctrl.last       = last;
    assign q_ctrl.mismatch   = (eff_cols != eff_vlen);
    assign q_value           = req.elem_value;
    assign q_addr            = is_mat ? col_reg : CW'(req.elem_index);
    assign q_row             = row_reg;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= mvm_pkg::CFG_W'(1);
            rows_reg <= mvm_pkg::CFG_W'(1);
            vlen_reg <= mvm_pkg::CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mvm_pkg::CFG_NUM_COLS:   cols_reg <= cfg_data;
                mvm_pkg::CFG_NUM_ROWS:   rows_reg <= cfg_data;
                mvm_pkg::CFG_VECTOR_LEN: vlen_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Advance column and row counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> hdl/mvm_queue.sv
// ============================================================================
// Matrix-vector multiply command queue
// Small FIFO between the front end and the datapath so each side can stall
// on its own.
// ============================================================================
module mvm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW = $clog2(DEPTH),
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic [NW-1:0]    count_next;
    logic             do_pop;

    assign full      = (count_reg == NW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + NW'(1);
        else if (!push && do_pop)
            count_next = count_reg - NW'(1);
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
    end

endmodule

>>> hdl/mvm_back.sv
// ============================================================================
// Matrix-vector multiply datapath
// Owns the vector store, reads the element for each column, multiplies and
// accumulates, and holds each row result in an output register.
// ============================================================================
module mvm_back #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    localparam int CW = $clog2(MAX_COLS),
    localparam int RW = $clog2(MAX_ROWS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  mvm_pkg::mvm_ctrl_t                  q_ctrl,
    input  logic signed [mvm_pkg::VAL_W-1:0]    q_value,
    input  logic [CW-1:0]                       q_addr,
    input  logic [RW-1:0]                       q_row,
    mvm_res_if.source                           res
);

    localparam int SW = mvm_pkg::SUM_W;
    localparam int PW = mvm_pkg::PROD_W;

    logic signed [mvm_pkg::VAL_W-1:0] vec_mem [MAX_COLS];

    // Read stage
    logic                             rd_valid_reg;
    mvm_pkg::mvm_ctrl_t               rd_ctrl_reg;
    logic signed [mvm_pkg::VAL_W-1:0] rd_value_reg;
    logic signed [mvm_pkg::VAL_W-1:0] rd_data_reg;
    logic [RW-1:0]                    rd_row_reg;

    // Product stage
    logic                             mul_valid_reg;
    mvm_pkg::mvm_ctrl_t               mul_ctrl_reg;
    logic signed [PW-1:0]             prod_reg;
    logic [RW-1:0]                    mul_row_reg;

    // Accumulate and output stage
    logic signed [SW-1:0]             acc_reg;
    logic signed [SW-1:0]             acc_next;
    logic signed [SW:0]               acc_sum;
    logic                             res_valid_reg;
    logic signed [SW-1:0]             sum_reg;
    logic [RW-1:0]                    row_out_reg;
    logic                             last_reg;
    logic                             status_reg;

    logic                             adv;

    // The whole pipeline moves when the output register can take a result
    assign adv   = !res_valid_reg || res.ready;
    assign q_pop = adv && q_valid;

    // Add with saturation to the sum range
    always_comb
    begin
        acc_sum  = {acc_reg[SW-1], acc_reg} + (SW + 1)'(prod_reg);
        acc_next = acc_sum[SW-1:0];
        if (acc_sum[SW] != acc_sum[SW-1])
            acc_next = acc_sum[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
    end

    // Vector store: write on loads, registered read for matrix elements
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (q_valid && !q_ctrl.is_mat)
                vec_mem[q_addr] <= q_value;
            rd_data_reg <= vec_mem[q_addr];
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_ctrl_reg  <= q_ctrl;
            rd_value_reg <= q_value;
            rd_row_reg   <= q_row;
            mul_ctrl_reg <= rd_ctrl_reg;
            prod_reg     <= rd_value_reg * rd_data_reg;
            mul_row_reg  <= rd_row_reg;
            if (mul_valid_reg && mul_ctrl_reg.row_end)
            begin
                sum_reg     <= mul_ctrl_reg.mismatch ? '0 : acc_next;
                row_out_reg <= mul_row_reg;
                last_reg    <= mul_ctrl_reg.last;
                status_reg  <= mul_ctrl_reg.mismatch ? mvm_pkg::STATUS_MISMATCH
                                                     : mvm_pkg::STATUS_OK;
            end
        end
    end

    // Stage valids and the row accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else if (adv)
        begin
            rd_valid_reg  <= q_valid && q_ctrl.is_mat;
            mul_valid_reg <= rd_valid_reg;
            res_valid_reg <= mul_valid_reg && mul_ctrl_reg.row_end;
            if (mul_valid_reg)
                acc_reg <= mul_ctrl_reg.row_end ? '0 : acc_next;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.row_sum   = sum_reg;
    assign res.row_index = mvm_pkg::IDX_W'(row_out_reg);
    assign res.last_row  = last_reg;
    assign res.status    = status_reg;

`ifndef SYNTHESIS
    // A mismatch result always carries a zero sum
    a_mismatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (status_reg == mvm_pkg::STATUS_MISMATCH) |-> sum_reg == '0)
        else $error("mismatch result with nonzero sum");

    // The accumulator is empty after a row end
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        adv && mul_valid_reg && mul_ctrl_reg.row_end |=> acc_reg == '0)
        else $error("accumulator not cleared at row end");

    // A stalled product stage keeps its product
    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mul_valid_reg && !adv |=> mul_valid_reg && $stable(prod_reg))
        else $error("product lost during stall");

    // Nothing is popped while the output register is blocked
    a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |-> !q_pop)
        else $error("queue popped while output blocked");
`endif

endmodule

>>> hdl/matrix_vector_multiply.sv
// ============================================================================
// Matrix-vector multiply-accumulate
// Loads vector elements into a store, streams matrix elements row by row and
// returns one Q14.24 dot product per row.
// ============================================================================
//
//  Channel  Dir  Handshake          Payload
//  req      in   valid/ready        req_type, elem_value, elem_index
//  res      out  valid/ready        row_sum, row_index, last_row, status
//  cfg      in   cfg_we, no stall   cfg_index, cfg_data
//
//  One item per cycle while req ready is high; each matrix element costs one
//  multiply-accumulate. A row result passes the queue, store read, multiply and
//  accumulate into the output register before it is valid.
//  Vector loads leave no result; the vector store is not cleared at reset.
//  A stalled result halts the datapath; req takes up to four more items into
//  the 4-entry queue, then ready drops until the datapath moves again.
//
module matrix_vector_multiply #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mvm_req_if.sink                         req,
    mvm_res_if.source                       res,
    input  logic                            cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]       cfg_data
);

    localparam int CW      = $clog2(MAX_COLS);
    localparam int RW      = $clog2(MAX_ROWS);
    localparam int CTRL_W  = $bits(mvm_pkg::mvm_ctrl_t);
    localparam int ENTRY_W = CTRL_W + mvm_pkg::VAL_W + CW + RW;

    logic                             f_push;
    mvm_pkg::mvm_ctrl_t               f_ctrl;
    logic signed [mvm_pkg::VAL_W-1:0] f_value;
    logic [CW-1:0]                    f_addr;
    logic [RW-1:0]                    f_row;
    logic                             q_full;
    logic                             q_pop;
    logic                             q_valid;
    logic [ENTRY_W-1:0]               q_data;
    mvm_pkg::mvm_ctrl_t               b_ctrl;
    logic signed [mvm_pkg::VAL_W-1:0] b_value;
    logic [CW-1:0]                    b_addr;
    logic [RW-1:0]                    b_row;

    mvm_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (f_push),
        .q_ctrl    (f_ctrl),
        .q_value   (f_value),
        .q_addr    (f_addr),
        .q_row     (f_row)
    );

    mvm_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data ({f_ctrl, f_value, f_addr, f_row}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    // Unpack the queue entry
    assign {b_ctrl, b_value, b_addr, b_row} = q_data;

    mvm_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_ctrl  (b_ctrl),
        .q_value (b_value),
        .q_addr  (b_addr),
        .q_row   (b_row),
        .res     (res)
    );

endmodule
